// ===== rtl/mdcl_pkg.sv =====
// Shared types, codes and constants of the Morse digit code lock.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mdcl_pkg;

  localparam int ECHO_W      = 20;
  localparam int RUN_W       = 8;
  localparam int CODE_W      = 16;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;
  localparam int SYM_CNT_W   = 3;
  localparam int GROUP_LEN   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int CODE_DIGITS_DEF = 4;

  localparam logic [ECHO_W-1:0] ECHO_LIMIT_RST  = 20'd10000;
  localparam logic [RUN_W-1:0]  DASH_MIN_RST    = 8'd3;
  localparam logic [CODE_W-1:0] SECRET_CODE_RST = 16'h8152;
  localparam logic [RUN_W-1:0]  RUN_MAX         = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE = 2'd2;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ARM    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    K_SAMPLE = 2'd0,
    K_ARM    = 2'd1,
    K_CLEAR  = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  near;
  } entry_t;

  localparam logic [1:0] SYM_NONE = 2'd0;
  localparam logic [1:0] SYM_DOT  = 2'd1;
  localparam logic [1:0] SYM_DASH = 2'd2;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_OK    = 2'd1;
  localparam logic [1:0] VERDICT_WRONG = 2'd2;

  typedef struct packed {
    logic       armed;
    logic [1:0] digits_held;
    logic [1:0] verdict;
    logic [3:0] digit_value;
    logic       digit_done;
    logic [1:0] symbol_added;
    logic       near;
  } result_t;

  // dash = 1, first symbol in the top bit
  function automatic logic [3:0] decode_group(input logic [GROUP_LEN-1:0] bits);
    logic [3:0] d;
    case (bits)
      5'b01111: d = 4'd1;
      5'b00111: d = 4'd2;
      5'b00011: d = 4'd3;
      5'b00001: d = 4'd4;
      5'b00000: d = 4'd5;
      5'b10000: d = 4'd6;
      5'b11000: d = 4'd7;
      5'b11100: d = 4'd8;
      5'b11110: d = 4'd9;
      default:  d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/morse_digit_code_lock_unit.sv =====
// Top level of the Morse digit code lock: configuration registers, front end,
// entry queue and back end. Depends on mdcl_pkg, mdcl_front, mdcl_queue, mdcl_back.
//
//   channel  dir  ports                       contents
//   in       in   in_tvalid/tready/tdata/tuser tuser = operation, tdata = echo_us
//   out      out  out_tvalid/tready/tdata      one result beat per input beat
//   cfg      in   cfg_we/cfg_index/cfg_wdata   register write, no read-back
//
// One beat per cycle sustained while the output is not stalled; each beat is
// classified into the queue, then its state update goes into the output register.
// The back end updates its state as it takes each entry, which sets the rate.
// Synchronous active-low reset clears all entry state and restores registers.
// A stalled output holds its beat; the queue keeps accepting until full.
`timescale 1ns / 1ps

module morse_digit_code_lock_unit
  import mdcl_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [19:0] echo_us
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] near, [2:1] symbol_added, [3] digit_done,
                                            // [7:4] digit_value, [9:8] verdict,
                                            // [11:10] digits_held, [12] armed
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [ECHO_W-1:0] echo_limit_r;
  logic [RUN_W-1:0]  dash_min_r;
  logic [CODE_W-1:0] secret_r;
  entry_t            front_entry;
  entry_t            q_entry;
  logic              q_full, q_valid, q_take;
  result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_limit_r <= ECHO_LIMIT_RST;
      dash_min_r   <= DASH_MIN_RST;
      secret_r     <= SECRET_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ECHO_LIMIT:  echo_limit_r <= cfg_wdata[ECHO_W-1:0];
        REG_DASH_MIN:    dash_min_r   <= cfg_wdata[RUN_W-1:0];
        REG_SECRET_CODE: secret_r     <= cfg_wdata[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mdcl_front u_front (
    .operation  (in_tuser[1:0]),
    .echo_us    (in_tdata[ECHO_W-1:0]),
    .echo_limit (echo_limit_r),
    .entry      (front_entry)
  );

  assign in_tready = !q_full;

  mdcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_take),
    .not_empty (q_valid),
    .pop_data  (q_entry)
  );

  mdcl_back #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_valid  (q_valid),
    .entry        (q_entry),
    .entry_take   (q_take),
    .dash_min_run (dash_min_r),
    .secret_code  (secret_r),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res          (res)
  );

  assign out_tdata = OUT_DATA_W'(res);

endmodule

// ===== rtl/mdcl_front.sv =====
// Front end: classifies each input beat into an operation kind and a near flag.
// Depends on mdcl_pkg.
`timescale 1ns / 1ps

module mdcl_front
  import mdcl_pkg::*;
(
  input  logic [1:0]        operation,
  input  logic [ECHO_W-1:0] echo_us,
  input  logic [ECHO_W-1:0] echo_limit,
  output entry_t            entry
);

  always_comb begin
    entry.near = (echo_us != '0) && (echo_us < echo_limit);
    case (operation)
      OP_SAMPLE: entry.kind = K_SAMPLE;
      OP_ARM:    entry.kind = K_ARM;
      OP_CLEAR:  entry.kind = K_CLEAR;
      default:   entry.kind = K_NONE;
    endcase
  end

endmodule

// ===== rtl/mdcl_queue.sv =====
// Short queue of classified entries between front and back end.
// Depends on mdcl_pkg.
`timescale 1ns / 1ps

module mdcl_queue
  import mdcl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mdcl_back.sv =====
// Back end: symbol, digit and code-entry state, with the registered result.
// Depends on mdcl_pkg.
`timescale 1ns / 1ps

module mdcl_back
  import mdcl_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              entry_valid,
  input  entry_t            entry,
  output logic              entry_take,
  input  logic [RUN_W-1:0]  dash_min_run,
  input  logic [CODE_W-1:0] secret_code,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int DC_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  logic                 armed_r, armed_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [SYM_CNT_W-1:0] sym_cnt_r, sym_cnt_nxt;
  logic [GROUP_LEN-1:0] bits_r, bits_nxt;
  logic [DC_W-1:0]      dc_r, dc_nxt;
  logic                 match_r, match_nxt;
  logic                 out_valid_r;
  result_t              out_r, out_nxt;
  logic                 dash;
  logic [3:0]           dval;
  logic [3:0]           want;
  logic [7:0]           held_ext;
  int                   pos;

  assign entry_take = entry_valid && (!out_valid_r || res_ready);
  assign res_valid  = out_valid_r;
  assign res        = out_r;

  always_comb begin
    pos  = CODE_DIGITS - 1 - int'(dc_r);
    want = '0;
    for (int j = 0; j < 4; j++) begin
      if (pos == j) begin
        want = secret_code[j*4 +: 4];
      end
    end
  end

  always_comb begin
    armed_nxt   = armed_r;
    run_nxt     = run_r;
    sym_cnt_nxt = sym_cnt_r;
    bits_nxt    = bits_r;
    dc_nxt      = dc_r;
    match_nxt   = match_r;
    dash        = run_r >= dash_min_run;
    dval        = '0;
    out_nxt     = '0;
    case (entry.kind)
      K_CLEAR: begin
        armed_nxt   = 1'b0;
        run_nxt     = '0;
        sym_cnt_nxt = '0;
        bits_nxt    = '0;
        dc_nxt      = '0;
        match_nxt   = 1'b1;
      end
      K_ARM: begin
        armed_nxt = 1'b1;
      end
      K_SAMPLE: begin
        if (armed_r) begin
          if (entry.near) begin
            out_nxt.near = 1'b1;
            if (run_r != RUN_MAX) begin
              run_nxt = run_r + 1'b1;
            end
          end else begin
            run_nxt = '0;
            if (run_r != '0) begin
              out_nxt.symbol_added = dash ? SYM_DASH : SYM_DOT;
              bits_nxt    = {bits_r[GROUP_LEN-2:0], dash};
              sym_cnt_nxt = sym_cnt_r + 1'b1;
            end
          end
          if (sym_cnt_nxt >= SYM_CNT_W'(GROUP_LEN)) begin
            dval                = decode_group(bits_nxt);
            out_nxt.digit_done  = 1'b1;
            out_nxt.digit_value = dval;
            bits_nxt            = '0;
            sym_cnt_nxt         = '0;
            armed_nxt           = 1'b0;
            match_nxt           = match_r && (dval == want);
            if (dc_r == DC_W'(CODE_DIGITS - 1)) begin
              out_nxt.verdict = match_nxt ? VERDICT_OK : VERDICT_WRONG;
              run_nxt         = '0;
              dc_nxt          = '0;
              match_nxt       = 1'b1;
            end else begin
              dc_nxt = dc_r + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    held_ext            = 8'(dc_nxt);
    out_nxt.digits_held = held_ext[1:0];
    out_nxt.armed       = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      run_r       <= '0;
      sym_cnt_r   <= '0;
      bits_r      <= '0;
      dc_r        <= '0;
      match_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (entry_take) begin
        armed_r   <= armed_nxt;
        run_r     <= run_nxt;
        sym_cnt_r <= sym_cnt_nxt;
        bits_r    <= bits_nxt;
        dc_r      <= dc_nxt;
        match_r   <= match_nxt;
      end
      if (entry_take) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_take) begin
      out_r <= out_nxt;
    end
  end

endmodule
